// ----- rtl/core/cartesian_to_polar_quadrant_defines.svh -----
// -----------------------------------------------------------------------------
// cartesian_to_polar_quadrant_defines.svh
// Assertion macros shared by the checker of the polar converter.
// -----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_QUADRANT_DEFINES_SVH
`define CARTESIAN_TO_POLAR_QUADRANT_DEFINES_SVH

// Overlapping implication, sampled on clk, off while rst is high.
`define CPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpq check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpq check failed");

`endif

// ----- rtl/core/cpq_pkg.sv -----
// -----------------------------------------------------------------------------
// cpq_pkg
// Shared constants, control struct and arctangent table of the polar converter.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpq_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int GUARD_BITS        = 16;
  localparam int TABLE_LEN         = 24;
  localparam int ACC_W             = 25;  // angle accumulator, 2^-16 degree
  localparam int ANGLE_W           = 16;

  localparam logic signed [ACC_W-1:0]   DEG90       = 25'sd5898240;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       origin;
    logic [1:0] quad;
  } ctl_t;

  // atan(2^-i) in degrees, scaled by 65536, rounded
  function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      0:       v = 25'sd2949120;
      1:       v = 25'sd1740967;
      2:       v = 25'sd919879;
      3:       v = 25'sd466945;
      4:       v = 25'sd234379;
      5:       v = 25'sd117304;
      6:       v = 25'sd58666;
      7:       v = 25'sd29335;
      8:       v = 25'sd14668;
      9:       v = 25'sd7334;
      10:      v = 25'sd3667;
      11:      v = 25'sd1833;
      12:      v = 25'sd917;
      13:      v = 25'sd458;
      14:      v = 25'sd229;
      15:      v = 25'sd115;
      16:      v = 25'sd57;
      17:      v = 25'sd29;
      18:      v = 25'sd14;
      19:      v = 25'sd7;
      20:      v = 25'sd4;
      21:      v = 25'sd2;
      22:      v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/cpq_prep.sv -----
// -----------------------------------------------------------------------------
// cpq_prep
// Front stages: quadrant code, +-90 degree pre-rotation, squares, square sum.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpq_prep #(
  parameter int W  = cpq_pkg::COORD_WIDTH_DEF,
  parameter int CW = cpq_pkg::COORD_WIDTH_DEF + 2 + cpq_pkg::GUARD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [W-1:0]                 x_coord,
  input  logic signed [W-1:0]                 y_coord,
  output cpq_pkg::ctl_t                       ctl_o,
  output logic signed [CW-1:0]                cx_o,
  output logic signed [CW-1:0]                cy_o,
  output logic signed [cpq_pkg::ACC_W-1:0]    acc_o,
  output logic [2*W-1:0]                      sum_o
);

  logic                              x_neg;
  logic                              y_neg;
  logic signed [W:0]                 xe;
  logic signed [W:0]                 ye;
  logic signed [W:0]                 rx;
  logic signed [W:0]                 ry;
  logic signed [cpq_pkg::ACC_W-1:0]  racc;
  logic signed [2*W-1:0]             px;
  logic signed [2*W-1:0]             py;
  cpq_pkg::ctl_t                     ctl_next;

  cpq_pkg::ctl_t                     ctl1;
  logic signed [W:0]                 rx1;
  logic signed [W:0]                 ry1;
  logic signed [cpq_pkg::ACC_W-1:0]  acc1;
  logic [2*W-2:0]                    sqx1;
  logic [2*W-2:0]                    sqy1;
  cpq_pkg::ctl_t                     ctl2;

  assign x_neg = x_coord[W-1];
  assign y_neg = y_coord[W-1];
  assign xe    = {x_coord[W-1], x_coord};
  assign ye    = {y_coord[W-1], y_coord};
  assign px    = x_coord * x_coord;
  assign py    = y_coord * y_coord;

  always_comb begin
    ctl_next.valid  = in_valid;
    ctl_next.origin = (x_coord == '0) && (y_coord == '0);
    if (!x_neg && !y_neg) begin
      ctl_next.quad = cpq_pkg::QUAD_FIRST;
    end else if (x_neg && !y_neg) begin
      ctl_next.quad = cpq_pkg::QUAD_SECOND;
    end else if (x_neg) begin
      ctl_next.quad = cpq_pkg::QUAD_THIRD;
    end else begin
      ctl_next.quad = cpq_pkg::QUAD_FOURTH;
    end
    // fold left half plane into the right one
    if (x_neg && !y_neg) begin
      rx   = ye;
      ry   = -xe;
      racc = cpq_pkg::DEG90;
    end else if (x_neg) begin
      rx   = -ye;
      ry   = xe;
      racc = -cpq_pkg::DEG90;
    end else begin
      rx   = xe;
      ry   = ye;
      racc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else begin
      ctl1 <= ctl_next;
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    rx1   <= rx;
    ry1   <= ry;
    acc1  <= racc;
    sqx1  <= px[2*W-2:0];
    sqy1  <= py[2*W-2:0];
    cx_o  <= {rx1[W], rx1, {cpq_pkg::GUARD_BITS{1'b0}}};
    cy_o  <= {ry1[W], ry1, {cpq_pkg::GUARD_BITS{1'b0}}};
    acc_o <= acc1;
    sum_o <= {1'b0, sqx1} + {1'b0, sqy1};
  end

  assign ctl_o = ctl2;

endmodule

// ----- rtl/core/cpq_stage.sv -----
// -----------------------------------------------------------------------------
// cpq_stage
// One pipeline step: a CORDIC vectoring micro-rotation and one square-root bit.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpq_stage #(
  parameter int W      = cpq_pkg::COORD_WIDTH_DEF,
  parameter int CW     = cpq_pkg::COORD_WIDTH_DEF + 2 + cpq_pkg::GUARD_BITS,
  parameter int STAGES = cpq_pkg::CORDIC_STAGES_DEF,
  parameter int IDX    = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cpq_pkg::ctl_t                       ctl_i,
  input  logic signed [CW-1:0]                cx_i,
  input  logic signed [CW-1:0]                cy_i,
  input  logic signed [cpq_pkg::ACC_W-1:0]    acc_i,
  input  logic [2*W-1:0]                      rem_i,
  input  logic [W-1:0]                        root_i,
  output cpq_pkg::ctl_t                       ctl_o,
  output logic signed [CW-1:0]                cx_o,
  output logic signed [CW-1:0]                cy_o,
  output logic signed [cpq_pkg::ACC_W-1:0]    acc_o,
  output logic [2*W-1:0]                      rem_o,
  output logic [W-1:0]                        root_o
);

  logic signed [CW-1:0]               cx_next;
  logic signed [CW-1:0]               cy_next;
  logic signed [cpq_pkg::ACC_W-1:0]   acc_next;
  logic [2*W-1:0]                     rem_next;
  logic [W-1:0]                       root_next;

  generate
    if (IDX < STAGES && IDX < cpq_pkg::TABLE_LEN) begin : g_rot
      localparam logic signed [cpq_pkg::ACC_W-1:0] STEP = cpq_pkg::atan_entry(IDX);
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      assign dx = cy_i >>> IDX;
      assign dy = cx_i >>> IDX;
      always_comb begin
        if (!cy_i[CW-1]) begin
          cx_next  = cx_i + dx;
          cy_next  = cy_i - dy;
          acc_next = acc_i + STEP;
        end else begin
          cx_next  = cx_i - dx;
          cy_next  = cy_i + dy;
          acc_next = acc_i - STEP;
        end
      end
    end else begin : g_rot_hold
      assign cx_next  = cx_i;
      assign cy_next  = cy_i;
      assign acc_next = acc_i;
    end

    if (IDX < W) begin : g_sqrt
      localparam int B  = W - 1 - IDX;
      localparam int DW = 2 * W + 1;
      localparam logic [W-1:0] BIT_MASK = W'(1) << B;
      logic [DW-1:0] delta;
      // (root + 2^B)^2 - root^2, root holds bits above B only
      assign delta = (DW'(root_i) << (B + 1)) + (DW'(1) << (2 * B));
      always_comb begin
        if ({1'b0, rem_i} >= delta) begin
          rem_next  = rem_i - delta[2*W-1:0];
          root_next = root_i | BIT_MASK;
        end else begin
          rem_next  = rem_i;
          root_next = root_i;
        end
      end
    end else begin : g_sqrt_hold
      assign rem_next  = rem_i;
      assign root_next = root_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    cx_o   <= cx_next;
    cy_o   <= cy_next;
    acc_o  <= acc_next;
    rem_o  <= rem_next;
    root_o <= root_next;
  end

endmodule

// ----- rtl/core/cpq_post.sv -----
// -----------------------------------------------------------------------------
// cpq_post
// Last stage: radius rounding, angle rounding and clamp, result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpq_post #(
  parameter int W = cpq_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpq_pkg::ctl_t                         ctl_i,
  input  logic signed [cpq_pkg::ACC_W-1:0]      acc_i,
  input  logic [2*W-1:0]                        rem_i,
  input  logic [W-1:0]                          root_i,
  output logic                                  done,
  output logic [W-1:0]                          radius,
  output logic signed [cpq_pkg::ANGLE_W-1:0]    angle_deg,
  output logic [1:0]                            quadrant
);

  localparam int RW = cpq_pkg::ACC_W + 1;
  localparam int QW = cpq_pkg::ACC_W - 8;

  logic signed [RW-1:0]                    acc_r;
  logic signed [QW-1:0]                    acc_q;
  logic signed [cpq_pkg::ANGLE_W-1:0]      angle_next;
  logic [W-1:0]                            radius_next;

  // floor((acc + 256) / 512)
  assign acc_r = {acc_i[cpq_pkg::ACC_W-1], acc_i} + RW'(256);
  assign acc_q = acc_r[RW-1:9];

  always_comb begin
    if (ctl_i.origin) begin
      angle_next = '0;
    end else if (acc_q > cpq_pkg::ANGLE_LIMIT) begin
      angle_next = cpq_pkg::ANGLE_LIMIT;
    end else if (acc_q < -cpq_pkg::ANGLE_LIMIT) begin
      angle_next = -cpq_pkg::ANGLE_LIMIT;
    end else begin
      angle_next = acc_q[cpq_pkg::ANGLE_W-1:0];
    end
  end

  // round up when remainder exceeds root
  assign radius_next = root_i + W'(rem_i > {{W{1'b0}}, root_i});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    radius    <= radius_next;
    angle_deg <= angle_next;
    quadrant  <= ctl_i.quad;
  end

endmodule

// ----- rtl/core/cartesian_to_polar_quadrant.sv -----
// -----------------------------------------------------------------------------
// cartesian_to_polar_quadrant
// Throughput: one item per cycle; busy is always low, so start may be high in
// every cycle. The rate is set by the fully pipelined CORDIC and root chain.
// Reset: synchronous rst clears every stage valid bit; items in flight are
// dropped and no done strobe follows until new items enter. Results can not
// be stalled: done is high for one cycle per item.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_polar_quadrant #(
  parameter int COORD_WIDTH   = cpq_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = cpq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         x_coord,
  input  logic signed [COORD_WIDTH-1:0]         y_coord,
  output logic                                  done,
  output logic [COORD_WIDTH-1:0]                radius,
  output logic signed [cpq_pkg::ANGLE_W-1:0]    angle_deg,
  output logic [1:0]                            quadrant
);

  // One pipeline step carries a CORDIC micro-rotation and a square-root bit;
  // the longer of the two chains sets the step count, the other one idles.
  localparam int NSTEP = (COORD_WIDTH > CORDIC_STAGES) ? COORD_WIDTH : CORDIC_STAGES;
  // CORDIC datapath: coordinate, sign headroom for the gain, guard bits.
  localparam int CW    = COORD_WIDTH + 2 + cpq_pkg::GUARD_BITS;

  logic in_valid;

  // per-step signals, index 0 is the output of the front stages
  cpq_pkg::ctl_t                      ctl_s  [0:NSTEP];
  logic signed [CW-1:0]               cx_s   [0:NSTEP];
  logic signed [CW-1:0]               cy_s   [0:NSTEP];
  logic signed [cpq_pkg::ACC_W-1:0]   acc_s  [0:NSTEP];
  logic [2*COORD_WIDTH-1:0]           rem_s  [0:NSTEP];
  logic [COORD_WIDTH-1:0]             root_s [0:NSTEP];

  // Never stalls: every stage moves each cycle and the receiver can not push
  // back, so an item is taken whenever start is high.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // Two front stages: quadrant code, pre-rotation and squares, then the sum
  // x*x + y*y and the guard-bit shift into the CORDIC width.
  cpq_prep #(
    .W  (COORD_WIDTH),
    .CW (CW)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .ctl_o    (ctl_s[0]),
    .cx_o     (cx_s[0]),
    .cy_o     (cy_s[0]),
    .acc_o    (acc_s[0]),
    .sum_o    (rem_s[0])
  );

  assign root_s[0] = '0;

  // Step k rotates by atan(2^-k) and settles root bit COORD_WIDTH-1-k.
  genvar k;
  generate
    for (k = 0; k < NSTEP; k++) begin : g_step
      cpq_stage #(
        .W      (COORD_WIDTH),
        .CW     (CW),
        .STAGES (CORDIC_STAGES),
        .IDX    (k)
      ) u_stage (
        .clk    (clk),
        .rst    (rst),
        .ctl_i  (ctl_s[k]),
        .cx_i   (cx_s[k]),
        .cy_i   (cy_s[k]),
        .acc_i  (acc_s[k]),
        .rem_i  (rem_s[k]),
        .root_i (root_s[k]),
        .ctl_o  (ctl_s[k+1]),
        .cx_o   (cx_s[k+1]),
        .cy_o   (cy_s[k+1]),
        .acc_o  (acc_s[k+1]),
        .rem_o  (rem_s[k+1]),
        .root_o (root_s[k+1])
      );
    end
  endgenerate

  // Last stage: root rounding from the remainder, angle to 1/128 degree with
  // clamp to +-180, origin forced to angle 0. The final vector length is not
  // needed since the radius comes from the exact root.
  cpq_post #(
    .W (COORD_WIDTH)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .ctl_i     (ctl_s[NSTEP]),
    .acc_i     (acc_s[NSTEP]),
    .rem_i     (rem_s[NSTEP]),
    .root_i    (root_s[NSTEP]),
    .done      (done),
    .radius    (radius),
    .angle_deg (angle_deg),
    .quadrant  (quadrant)
  );

endmodule

// ----- rtl/core/cpq_checker.sv -----
// -----------------------------------------------------------------------------
// cpq_checker
// Port-level checks of the polar converter, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cartesian_to_polar_quadrant_defines.svh"

module cpq_checker #(
  parameter int COORD_WIDTH   = cpq_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = cpq_pkg::CORDIC_STAGES_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic signed [COORD_WIDTH-1:0]         x_coord,
  input logic signed [COORD_WIDTH-1:0]         y_coord,
  input logic                                  done,
  input logic [COORD_WIDTH-1:0]                radius,
  input logic signed [cpq_pkg::ANGLE_W-1:0]    angle_deg,
  input logic [1:0]                            quadrant
);

  localparam int NSTEP = (COORD_WIDTH > CORDIC_STAGES) ? COORD_WIDTH : CORDIC_STAGES;
  localparam int LAT   = NSTEP + 3;

  logic       x_neg;
  logic       y_neg;
  logic       at_origin;
  logic       polar_zero;
  logic [1:0] quad_in;

  assign x_neg      = x_coord[COORD_WIDTH-1];
  assign y_neg      = y_coord[COORD_WIDTH-1];
  assign at_origin  = (x_coord == '0) && (y_coord == '0);
  // quadrant code from the signs: {y sign, x sign ^ y sign}
  assign quad_in    = {y_neg, x_neg ^ y_neg};
  assign polar_zero = (radius == '0) && (angle_deg == '0) && (quadrant == cpq_pkg::QUAD_FIRST);

  // every item comes out after the fixed latency
  `CPQ_ASSERT_IMPL(a_item_done, start && !busy, ##LAT done)

  // no result without an item taken the fixed latency before
  `CPQ_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy && !rst, LAT))

  // quadrant code follows the input signs
  `CPQ_ASSERT_IMPL(a_quadrant, done, quadrant == $past(quad_in, LAT))

  // origin gives zero radius, zero angle, first quadrant
  `CPQ_ASSERT_IMPL(a_origin, done && $past(at_origin, LAT), polar_zero)

  // taking an item never makes the block busy
  `CPQ_ASSERT_NEXT(a_stays_ready, start && !busy, !busy)

endmodule

bind cartesian_to_polar_quadrant cpq_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_cpq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .x_coord   (x_coord),
  .y_coord   (y_coord),
  .done      (done),
  .radius    (radius),
  .angle_deg (angle_deg),
  .quadrant  (quadrant)
);

// ----- bench/testbench.sv -----
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartesian to polar converter. Points are sent
// through the start/busy handshake with random gaps. Every accepted point gets
// a predicted radius, angle and quadrant, and each done strobe is checked
// against the oldest prediction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CW          = cpq_pkg::COORD_WIDTH_DEF;
  localparam int STAGE_COUNT = cpq_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY     = ((CW > STAGE_COUNT) ? CW : STAGE_COUNT) + 3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int BURST_ITEMS  = 400;

  typedef struct {
    logic        [CW-1:0]               radius;
    logic signed [cpq_pkg::ANGLE_W-1:0] angle;
    logic        [1:0]                  quad;
  } polar_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic signed [CW-1:0] x_coord = '0;
  logic signed [CW-1:0] y_coord = '0;
  logic                 busy;
  logic                 done;
  logic [CW-1:0]        radius;
  logic signed [cpq_pkg::ANGLE_W-1:0] angle_deg;
  logic [1:0]           quadrant;

  polar_t pending_polar[$];
  int     mismatches = 0;
  int     stall_cycles = 0;

  // atan(2^-i) in degrees, 2^-16 degree units
  longint atan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  always #1 clk = ~clk;

  cartesian_to_polar_quadrant u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .done      (done),
    .radius    (radius),
    .angle_deg (angle_deg),
    .quadrant  (quadrant)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Integer square root, rounded to nearest (halves up).
  function automatic longint rounded_root(input longint n);
    longint rem;
    longint root;
    longint b;
    rem  = n;
    root = 0;
    b    = longint'(1) <<< 62;
    while (b > rem) b = b >>> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  // Vectoring CORDIC on 64-bit values; >>> on longint is a floor shift.
  function automatic logic signed [cpq_pkg::ANGLE_W-1:0] polar_angle(input longint xs,
                                                                     input longint ys);
    longint cx;
    longint cy;
    longint acc;
    longint dx;
    longint dy;
    if (xs == 0 && ys == 0) return '0;
    acc = 0;
    if (xs < 0 && ys >= 0) begin
      cx  = ys;
      cy  = -xs;
      acc = 90 * 65536;
    end else if (xs < 0) begin
      cx  = -ys;
      cy  = xs;
      acc = -90 * 65536;
    end else begin
      cx = xs;
      cy = ys;
    end
    cx = cx * 65536;
    cy = cy * 65536;
    for (int i = 0; i < STAGE_COUNT && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + atan_q16[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - atan_q16[i];
      end
    end
    acc = (acc + 256) >>> 9;
    if (acc > 23040) acc = 23040;
    if (acc < -23040) acc = -23040;
    return acc[cpq_pkg::ANGLE_W-1:0];
  endfunction

  function automatic polar_t polar_of(input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y);
    polar_t p;
    longint xs;
    longint ys;
    xs       = x;
    ys       = y;
    p.radius = CW'(rounded_root(xs * xs + ys * ys));
    p.angle  = polar_angle(xs, ys);
    if (xs >= 0 && ys >= 0)  p.quad = cpq_pkg::QUAD_FIRST;
    else if (xs < 0 && ys >= 0) p.quad = cpq_pkg::QUAD_SECOND;
    else if (xs < 0)         p.quad = cpq_pkg::QUAD_THIRD;
    else                     p.quad = cpq_pkg::QUAD_FOURTH;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Called at a rising edge; returns at the edge that accepted the item.
  // start is only lowered when a gap is taken, so back-to-back items keep it
  // high without a second assignment in one step.
  task automatic send_point(input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y,
                            input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (busy);
    pending_polar.push_back(polar_of(x, y));
  endtask

  // Mix of full range, tiny and extreme coordinates.
  function automatic logic signed [CW-1:0] pick_coord(input int kind);
    logic signed [CW-1:0] v;
    case (kind)
      0:       v = CW'($urandom);
      1:       v = CW'($signed($urandom_range(0, 32)) - 16);
      2:       v = $urandom_range(0, 1) ? CW'(16'sh7fff - $urandom_range(0, 3))
                                        : CW'(16'sh8000 + $urandom_range(0, 3));
      default: v = CW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random(input int count, input bit bursty);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    int shape;
    int gap;
    bit quiet;
    quiet = 1'b0;
    for (int n = 0; n < count; n++) begin
      // occasionally toggle into or out of a stretch with no gaps
      if ($urandom_range(0, 31) == 0) quiet = ~quiet;
      shape = int'($urandom_range(0, 19));
      if (shape < 10) begin
        x = pick_coord(0);
        y = pick_coord(0);
      end else if (shape < 14) begin
        x = pick_coord(1);
        y = pick_coord(1);
      end else if (shape < 16) begin
        x = pick_coord(int'($urandom_range(0, 2)));
        y = '0;
        if ($urandom_range(0, 1)) begin
          y = x;
          x = '0;
        end
      end else if (shape < 17) begin
        x = pick_coord(0);
        y = $urandom_range(0, 1) ? x : -x;
      end else begin
        x = pick_coord(int'($urandom_range(0, 2)));
        y = pick_coord(2);
        if ($urandom_range(0, 1)) begin
          x = y;
          y = pick_coord(int'($urandom_range(0, 2)));
        end
      end
      gap = (bursty || quiet) ? 0 : int'($urandom_range(0, 4));
      send_point(x, y, gap);
    end
  endtask

  // Stop sending until every predicted result has been checked.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_extremes();
    send_point(16'sd0, 16'sd0, 0);              // origin
    send_point(16'sh7fff, 16'sh7fff, 1);
    send_point(16'sh8000, 16'sh8000, 0);        // largest radius
    send_point(16'sh8000, 16'sh7fff, 2);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sd0, 0);
    send_point(16'sd0, 16'sh8000, 3);
    send_point(16'sh8000, 16'sh0001, 0);
    send_point(16'sh8000, 16'shffff, 4);
    send_point(16'shffff, 16'sh7fff, 0);
  endtask

  task automatic test_axes_and_quadrants();
    send_point(16'sh8000, 16'sd0, 0);           // negative x axis
    send_point(-16'sd1, 16'sd0, 1);
    send_point(16'sd0, 16'sh7fff, 0);           // positive y axis
    send_point(16'sd0, 16'sd1, 0);
    send_point(16'sd0, -16'sd1, 2);
    send_point(16'sd1, 16'sd0, 0);
    send_point(16'sd1, 16'sd1, 0);
    send_point(-16'sd1, 16'sd1, 1);
    send_point(-16'sd1, -16'sd1, 0);
    send_point(16'sd1, -16'sd1, 0);
    send_point(16'sd100, -16'sd100, 3);
    send_point(-16'sd300, 16'sd4, 0);
  endtask

  task automatic test_random_gaps();
    send_random(RANDOM_ITEMS, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_random(40, 1'b1);
    wait_for_drain();
    send_random(40, 1'b0);
  endtask

  task automatic test_back_to_back();
    send_random(BURST_ITEMS, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    polar_t want;
    if (!rst && done) begin
      if (pending_polar.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: radius %0d angle %0d quadrant %0d",
                 $time, radius, angle_deg, quadrant);
      end else begin
        want = pending_polar.pop_front();
        if (radius !== want.radius) begin
          mismatches++;
          $display("%0t: radius expected %0d actual %0d", $time, want.radius, radius);
        end
        if (angle_deg !== want.angle) begin
          mismatches++;
          $display("%0t: angle_deg expected %0d actual %0d",
                   $time, want.angle, angle_deg);
        end
        if (quadrant !== want.quad) begin
          mismatches++;
          $display("%0t: quadrant expected %0d actual %0d",
                   $time, want.quad, quadrant);
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted point nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_axes_and_quadrants();
    test_random_gaps();
    test_drain_pause();
    test_back_to_back();

    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
